### rtl/core/ygbd_pkg.sv
// Shared constants, configuration type and width helpers of the grid box decoder.
package ygbd_pkg;

   localparam int BOX_FIELDS  = 5;
   localparam int FRAC_BITS   = 14;
   localparam int DIM_W       = 13;
   localparam int THR_W       = 15;
   localparam int PIX_W       = 15;
   localparam int SCORE_W     = 16;
   localparam int POS_OUT_W   = 4;
   localparam int CLASS_OUT_W = 5;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // Position of each field inside one buffered box.
   localparam int FLD_X    = 0;
   localparam int FLD_Y    = 1;
   localparam int FLD_W    = 2;
   localparam int FLD_H    = 3;
   localparam int FLD_CONF = 4;

   localparam logic [1:0] REG_SCORE_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd1;
   localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd2;

   localparam logic [THR_W-1:0] THR_RESET = 15'd3277;
   localparam logic [DIM_W-1:0] DIM_RESET = 13'd448;

   localparam logic signed [PIX_W-1:0] PIX_MIN = 15'h4000;
   localparam logic signed [PIX_W-1:0] PIX_MAX = 15'h3FFF;

   typedef struct packed {
      logic [THR_W-1:0] score_threshold;
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
   } cfg_type;

   function automatic int imax(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   function automatic int cell_w(input int g);
      return $clog2(g);
   endfunction

   function automatic int cls_w(input int c);
      return (c > 1) ? $clog2(c) : 1;
   endfunction

   function automatic int slot_w(input int b);
      return (b > 1) ? $clog2(b) : 1;
   endfunction

   // Signed width of 2*(offset + cell*2^14) +/- GRID_SIZE*size.
   function automatic int num_w(input int vb, input int g);
      int a;
      a = imax(vb - 1, FRAC_BITS + $clog2(g)) + 1;
      return imax(a + 1, vb - 1 + $clog2(g + 1)) + 2;
   endfunction

   // Bits of |numerator * dimension| >> 14.
   function automatic int quot_w(input int vb, input int g);
      return num_w(vb, g) + DIM_W - 1 - FRAC_BITS;
   endfunction

   function automatic int mul_a_w(input int vb, input int g);
      return imax(imax(num_w(vb, g), quot_w(vb, g) + 1), vb);
   endfunction

   function automatic int mul_b_w(input int vb, input int g);
      return imax(imax(vb, DIM_W + 1), quot_w(vb, g) + 3);
   endfunction

endpackage

### rtl/core/ygbd_if.sv
// Valid/ready channel interfaces for prediction values and detections.
interface ygbd_req_if #(parameter int VALUE_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;
   logic                         frame_start;

   modport source (output valid, value, frame_start, input ready);
   modport sink (input valid, value, frame_start, output ready);
endinterface

interface ygbd_rsp_if import ygbd_pkg::*;;
   logic                          valid;
   logic                          ready;
   logic signed [PIX_W-1:0]       box_x;
   logic signed [PIX_W-1:0]       box_y;
   logic signed [PIX_W-1:0]       box_width;
   logic signed [PIX_W-1:0]       box_height;
   logic [CLASS_OUT_W-1:0]        class_index;
   logic [SCORE_W-1:0]            score;
   logic [POS_OUT_W-1:0]          cell_row;
   logic [POS_OUT_W-1:0]          cell_col;
   logic                          box_slot;
   logic                          last;

   modport source (output valid, box_x, box_y, box_width, box_height, class_index, score,
                   cell_row, cell_col, box_slot, last, input ready);
   modport sink (input valid, box_x, box_y, box_width, box_height, class_index, score,
                 cell_row, cell_col, box_slot, last, output ready);
endinterface

### rtl/core/yolo_grid_box_decoder.sv
// Top level of the grid box decoder: registers, cell buffer, sequencer, shared multiplier.
//
//   Channel   Direction  Handshake                      Carries
//   req_chan  in         valid/ready                    value, frame_start
//   rsp_chan  out        valid/ready                    box, class, score, cell, slot, last
//   csr_*     in         APB write at psel&penable      score_threshold, image_width/height
//
// A value that does not complete a cell is taken whenever the sequencer is idle.
// A value that completes a cell holds req_chan.ready low while the sequencer tests and emits
// the cell's boxes, and longer while the result register waits on rsp_chan.
// The score product, the corner product and every division by 2*GRID_SIZE use the shared multiplier.
// Reset is synchronous; the box store is not cleared and needs no clearing pass.
module yolo_grid_box_decoder import ygbd_pkg::*; #(
   parameter int GRID_SIZE      = 14,
   parameter int BOXES_PER_CELL = 2,
   parameter int CLASS_COUNT    = 20,
   parameter int VALUE_BITS     = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   ygbd_req_if.sink              req_chan,
   ygbd_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int BI_W = $clog2(BOX_FIELDS * BOXES_PER_CELL);
   localparam int CW   = cell_w(GRID_SIZE);
   localparam int CLW  = cls_w(CLASS_COUNT);
   localparam int MA   = mul_a_w(VALUE_BITS, GRID_SIZE);
   localparam int MB   = mul_b_w(VALUE_BITS, GRID_SIZE);

   cfg_type                      cfg;
   logic                         accept;
   logic                         cell_last;
   logic                         seq_idle;
   logic                         advance;
   logic [BI_W-1:0]              rd_addr;
   logic signed [VALUE_BITS-1:0] rd_data;
   logic signed [VALUE_BITS-1:0] best_score;
   logic [CLW-1:0]               best_num;
   logic [CW-1:0]                row;
   logic [CW-1:0]                col;
   logic signed [MA-1:0]         mul_a;
   logic signed [MB-1:0]         mul_b;
   logic signed [MA+MB-1:0]      mul_p;

   assign req_chan.ready = seq_idle;
   assign accept         = req_chan.valid && seq_idle;

   ygbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ygbd_cell_buf #(
      .GRID_SIZE      (GRID_SIZE),
      .BOXES_PER_CELL (BOXES_PER_CELL),
      .CLASS_COUNT    (CLASS_COUNT),
      .VALUE_BITS     (VALUE_BITS)
   ) u_cell_buf (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .value       (req_chan.value),
      .frame_start (req_chan.frame_start),
      .cell_last   (cell_last),
      .advance     (advance),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .best_score  (best_score),
      .best_num    (best_num),
      .row         (row),
      .col         (col)
   );

   ygbd_mul_unit #(
      .A_W (MA),
      .B_W (MB)
   ) u_mul_unit (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   ygbd_seq #(
      .GRID_SIZE      (GRID_SIZE),
      .BOXES_PER_CELL (BOXES_PER_CELL),
      .CLASS_COUNT    (CLASS_COUNT),
      .VALUE_BITS     (VALUE_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .start      (accept && cell_last),
      .idle       (seq_idle),
      .advance    (advance),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .best_score (best_score),
      .best_num   (best_num),
      .row        (row),
      .col        (col),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .mul_p      (mul_p),
      .rsp        (rsp_chan)
   );

endmodule

### rtl/core/ygbd_csr.sv
// APB-style register file holding threshold and image size.
module ygbd_csr import ygbd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SCORE_THRESHOLD: cfg_in.score_threshold = csr_pwdata[THR_W-1:0];
            REG_IMAGE_WIDTH:     cfg_in.image_width     = csr_pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT:    cfg_in.image_height    = csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SCORE_THRESHOLD: csr_prdata = CSR_DATA_W'(cfg_ff.score_threshold);
         REG_IMAGE_WIDTH:     csr_prdata = CSR_DATA_W'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT:    csr_prdata = CSR_DATA_W'(cfg_ff.image_height);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{score_threshold: THR_RESET, image_width: DIM_RESET,
                     image_height: DIM_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/ygbd_cell_buf.sv
// Grid position counters, per-cell box store and running best class score.
module ygbd_cell_buf import ygbd_pkg::*; #(
   parameter int GRID_SIZE      = 14,
   parameter int BOXES_PER_CELL = 2,
   parameter int CLASS_COUNT    = 20,
   parameter int VALUE_BITS     = 16
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                accept,
   input  logic signed [VALUE_BITS-1:0]                        value,
   input  logic                                                frame_start,
   output logic                                                cell_last,
   input  logic                                                advance,
   input  logic [$clog2(BOX_FIELDS*BOXES_PER_CELL)-1:0]        rd_addr,
   output logic signed [VALUE_BITS-1:0]                        rd_data,
   output logic signed [VALUE_BITS-1:0]                        best_score,
   output logic [cls_w(CLASS_COUNT)-1:0]                       best_num,
   output logic [cell_w(GRID_SIZE)-1:0]                        row,
   output logic [cell_w(GRID_SIZE)-1:0]                        col
);

   localparam int BOX_CH  = BOX_FIELDS * BOXES_PER_CELL;
   localparam int CELL_CH = BOX_CH + CLASS_COUNT;
   localparam int CH_W    = $clog2(CELL_CH);
   localparam int BI_W    = $clog2(BOX_CH);
   localparam int CW      = cell_w(GRID_SIZE);
   localparam int CLW     = cls_w(CLASS_COUNT);

   logic [CH_W-1:0]              ch_ff, ch_in;
   logic [CW-1:0]                row_ff, row_in;
   logic [CW-1:0]                col_ff, col_in;
   logic signed [VALUE_BITS-1:0] best_ff, best_in;
   logic [CLW-1:0]               num_ff, num_in;
   logic signed [VALUE_BITS-1:0] box_mem [BOX_CH];
   logic [CH_W-1:0]              eff_ch;
   logic [CH_W-1:0]              cls;
   logic                         is_box;

   // A frame start puts this value at channel zero of cell (0,0).
   assign eff_ch    = frame_start ? '0 : ch_ff;
   assign cell_last = (eff_ch == CH_W'(CELL_CH - 1));
   assign is_box    = (eff_ch < CH_W'(BOX_CH));
   assign cls       = eff_ch - CH_W'(BOX_CH);

   assign rd_data    = box_mem[rd_addr];
   assign best_score = best_ff;
   assign best_num   = num_ff;
   assign row        = row_ff;
   assign col        = col_ff;

   always_comb begin
      ch_in   = ch_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      best_in = best_ff;
      num_in  = num_ff;
      if (accept) begin
         if (frame_start) begin
            row_in = '0;
            col_in = '0;
         end
         ch_in = cell_last ? '0 : eff_ch + CH_W'(1);
         if (!is_box && (cls == '0 || value > best_ff)) begin
            best_in = value;
            num_in  = CLW'(cls);
         end
      end
      if (advance) begin
         if (col_ff == CW'(GRID_SIZE - 1)) begin
            col_in = '0;
            row_in = (row_ff == CW'(GRID_SIZE - 1)) ? '0 : row_ff + CW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff   <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
         best_ff <= '0;
         num_ff  <= '0;
      end else begin
         ch_ff   <= ch_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         best_ff <= best_in;
         num_ff  <= num_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_box) begin
         box_mem[eff_ch[BI_W-1:0]] <= value;
      end
   end

endmodule

### rtl/core/ygbd_mul_unit.sv
// Shared signed multiplier with a registered product.
module ygbd_mul_unit #(
   parameter int A_W = 22,
   parameter int B_W = 22
) (
   input  logic                      clock,
   input  logic signed [A_W-1:0]     op_a,
   input  logic signed [B_W-1:0]     op_b,
   output logic signed [A_W+B_W-1:0] product
);

   logic signed [A_W+B_W-1:0] product_ff;

   assign product = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= (A_W + B_W)'(op_a) * (A_W + B_W)'(op_b);
   end

endmodule

### rtl/core/ygbd_seq.sv
// Per-cell sequencer: box tests, corner arithmetic on the shared multiplier, result register.
module ygbd_seq import ygbd_pkg::*; #(
   parameter int GRID_SIZE      = 14,
   parameter int BOXES_PER_CELL = 2,
   parameter int CLASS_COUNT    = 20,
   parameter int VALUE_BITS     = 16
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  cfg_type                                               cfg,
   input  logic                                                  start,
   output logic                                                  idle,
   output logic                                                  advance,
   output logic [$clog2(BOX_FIELDS*BOXES_PER_CELL)-1:0]          rd_addr,
   input  logic signed [VALUE_BITS-1:0]                          rd_data,
   input  logic signed [VALUE_BITS-1:0]                          best_score,
   input  logic [cls_w(CLASS_COUNT)-1:0]                         best_num,
   input  logic [cell_w(GRID_SIZE)-1:0]                          row,
   input  logic [cell_w(GRID_SIZE)-1:0]                          col,
   output logic signed [mul_a_w(VALUE_BITS, GRID_SIZE)-1:0]      mul_a,
   output logic signed [mul_b_w(VALUE_BITS, GRID_SIZE)-1:0]      mul_b,
   input  logic signed [mul_a_w(VALUE_BITS, GRID_SIZE)
                        + mul_b_w(VALUE_BITS, GRID_SIZE)-1:0]    mul_p,
   ygbd_rsp_if.source                                            rsp
);

   localparam int BI_W   = $clog2(BOX_FIELDS * BOXES_PER_CELL);
   localparam int CW     = cell_w(GRID_SIZE);
   localparam int SW     = slot_w(BOXES_PER_CELL);
   localparam int NUM_W  = num_w(VALUE_BITS, GRID_SIZE);
   localparam int PW     = NUM_W + DIM_W;
   localparam int QW     = quot_w(VALUE_BITS, GRID_SIZE);
   localparam int DIV    = 2 * GRID_SIZE;
   localparam int SH     = QW + $clog2(DIV);
   localparam int RW     = QW + 2;
   localparam int MA     = mul_a_w(VALUE_BITS, GRID_SIZE);
   localparam int MB     = mul_b_w(VALUE_BITS, GRID_SIZE);
   localparam int MW     = MA + MB;
   localparam int CMP_W  = imax(VALUE_BITS, THR_W + 1);
   // Reciprocal of 2*GRID_SIZE, rounded up; exact floor division for QW-bit dividends.
   localparam logic [63:0] RECIP64 = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
   localparam logic [RW-1:0] RECIP = RW'(RECIP64);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_SCORE = 11'b00000000010,
      S_TEST  = 11'b00000000100,
      S_PICK  = 11'b00000001000,
      S_OFF   = 11'b00000010000,
      S_SIZE  = 11'b00000100000,
      S_MUL1  = 11'b00001000000,
      S_MUL2  = 11'b00010000000,
      S_EDGE  = 11'b00100000000,
      S_EMIT  = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } seq_state_type;

   seq_state_type                state_ff, state_in;
   logic [SW-1:0]                slot_ff, slot_in;
   logic [1:0]                   e_ff, e_in;
   logic [BOXES_PER_CELL-1:0]    pass_ff, pass_in;
   logic [SCORE_W-1:0]           score_ff [BOXES_PER_CELL];
   logic [SCORE_W-1:0]           score_in [BOXES_PER_CELL];
   logic signed [VALUE_BITS-1:0] off_ff, off_in;
   logic signed [NUM_W-1:0]      num_ff, num_in;
   logic                         neg_ff, neg_in;
   logic signed [PIX_W-1:0]      edge_ff [4];
   logic signed [PIX_W-1:0]      edge_in [4];

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [PIX_W-1:0]      x_ff, x_in, y_ff, y_in, w_ff, w_in, h_ff, h_in;
   logic [CLASS_OUT_W-1:0]       cls_ff, cls_in;
   logic [SCORE_W-1:0]           sc_ff, sc_in;
   logic [POS_OUT_W-1:0]         row_out_ff, row_out_in, col_out_ff, col_out_in;
   logic                         slot_out_ff, slot_out_in, last_ff, last_in;

   logic                         axis, dir, last_slot, more, pass_now;
   logic [BI_W-1:0]              base_conf, addr_pos, addr_size;
   logic [CW-1:0]                grid_pos;
   logic [DIM_W-1:0]             dim;
   logic signed [NUM_W-1:0]      centre, gsize, num_calc;
   logic signed [PW-1:0]         prod_p, mag;
   logic [QW-1:0]                q, quot;
   logic signed [PIX_W-1:0]      edge_sat;
   logic [MW-FRAC_BITS-1:0]      score_raw;
   logic [SCORE_W-1:0]           score_sat;

   function automatic logic signed [PIX_W-1:0] sat_diff(input logic signed [PIX_W-1:0] hi,
                                                        input logic signed [PIX_W-1:0] lo);
      logic signed [PIX_W:0] d;
      d = (PIX_W + 1)'(hi) - (PIX_W + 1)'(lo);
      if (d > (PIX_W + 1)'(PIX_MAX)) return PIX_MAX;
      if (d < (PIX_W + 1)'(PIX_MIN)) return PIX_MIN;
      return d[PIX_W-1:0];
   endfunction

   assign axis      = e_ff[1];
   assign dir       = e_ff[0];
   assign last_slot = (slot_ff == SW'(BOXES_PER_CELL - 1));
   assign base_conf = BI_W'(int'(slot_ff) * BOX_FIELDS + FLD_CONF);
   assign addr_pos  = BI_W'(int'(slot_ff) * BOX_FIELDS + (axis ? FLD_Y : FLD_X));
   assign addr_size = BI_W'(int'(slot_ff) * BOX_FIELDS + (axis ? FLD_H : FLD_W));
   assign grid_pos  = axis ? row : col;
   assign dim       = axis ? cfg.image_height : cfg.image_width;

   // Doubled center in Q.14 plus or minus GRID_SIZE times the size.
   assign centre   = (NUM_W'(off_ff) + $signed(NUM_W'({grid_pos, {FRAC_BITS{1'b0}}}))) <<< 1;
   assign gsize    = NUM_W'(rd_data) * $signed(NUM_W'(GRID_SIZE));
   assign num_calc = dir ? centre + gsize : centre - gsize;

   // Truncation toward zero is done on the magnitude; the sign is applied at the end.
   assign prod_p = mul_p[PW-1:0];
   assign mag    = prod_p[PW-1] ? -prod_p : prod_p;
   assign q      = mag[PW-2:FRAC_BITS];
   assign quot   = mul_p[SH +: QW];

   always_comb begin
      if (neg_ff) begin
         edge_sat = (quot > QW'(16384)) ? PIX_MIN : -$signed(PIX_W'(quot));
      end else begin
         edge_sat = (quot > QW'(16383)) ? PIX_MAX : $signed(PIX_W'(quot));
      end
   end

   assign pass_now  = ($signed(CMP_W'(rd_data)) > $signed(CMP_W'(cfg.score_threshold)))
                   && ($signed(mul_p) > $signed(MW'({cfg.score_threshold,
                                                     {FRAC_BITS{1'b0}}})));
   assign score_raw = mul_p[MW-1:FRAC_BITS];
   assign score_sat = (score_raw > (MW - FRAC_BITS)'(16'hFFFF)) ? 16'hFFFF
                                                                 : score_raw[SCORE_W-1:0];

   always_comb begin
      more = 1'b0;
      for (int i = 0; i < BOXES_PER_CELL; i++) begin
         if (SW'(i) > slot_ff && pass_ff[i]) more = 1'b1;
      end
   end

   always_comb begin
      state_in    = state_ff;
      slot_in     = slot_ff;
      e_in        = e_ff;
      pass_in     = pass_ff;
      score_in    = score_ff;
      off_in      = off_ff;
      num_in      = num_ff;
      neg_in      = neg_ff;
      edge_in     = edge_ff;
      rd_addr     = base_conf;
      mul_a       = '0;
      mul_b       = '0;
      advance     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      x_in        = x_ff;
      y_in        = y_ff;
      w_in        = w_ff;
      h_in        = h_ff;
      cls_in      = cls_ff;
      sc_in       = sc_ff;
      row_out_in  = row_out_ff;
      col_out_in  = col_out_ff;
      slot_out_in = slot_out_ff;
      last_in     = last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SCORE;
               slot_in  = '0;
            end
         end
         S_SCORE: begin
            mul_a    = MA'(rd_data);
            mul_b    = MB'(best_score);
            state_in = S_TEST;
         end
         S_TEST: begin
            pass_in[slot_ff]  = pass_now;
            score_in[slot_ff] = score_sat;
            if (last_slot) begin
               slot_in  = '0;
               state_in = S_PICK;
            end else begin
               slot_in  = slot_ff + SW'(1);
               state_in = S_SCORE;
            end
         end
         S_PICK: begin
            if (pass_ff[slot_ff]) begin
               e_in     = '0;
               state_in = S_OFF;
            end else if (last_slot) begin
               state_in = S_DONE;
            end else begin
               slot_in = slot_ff + SW'(1);
            end
         end
         S_OFF: begin
            rd_addr  = addr_pos;
            off_in   = rd_data;
            state_in = S_SIZE;
         end
         S_SIZE: begin
            rd_addr  = addr_size;
            num_in   = num_calc;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            mul_a    = MA'(num_ff);
            mul_b    = MB'(dim);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            neg_in   = prod_p[PW-1];
            mul_a    = MA'(q);
            mul_b    = MB'(RECIP);
            state_in = S_EDGE;
         end
         S_EDGE: begin
            edge_in[e_ff] = edge_sat;
            if (e_ff == 2'd3) begin
               state_in = S_EMIT;
            end else begin
               e_in     = e_ff + 2'd1;
               state_in = S_OFF;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               x_in         = edge_ff[0];
               y_in         = edge_ff[2];
               w_in         = sat_diff(edge_ff[1], edge_ff[0]);
               h_in         = sat_diff(edge_ff[3], edge_ff[2]);
               cls_in       = CLASS_OUT_W'(best_num);
               sc_in        = score_ff[slot_ff];
               row_out_in   = POS_OUT_W'(row);
               col_out_in   = POS_OUT_W'(col);
               slot_out_in  = slot_ff[0];
               last_in      = !more;
               if (last_slot) begin
                  state_in = S_DONE;
               end else begin
                  slot_in  = slot_ff + SW'(1);
                  state_in = S_PICK;
               end
            end
         end
         S_DONE: begin
            advance  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign idle            = (state_ff == S_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.box_x       = x_ff;
   assign rsp.box_y       = y_ff;
   assign rsp.box_width   = w_ff;
   assign rsp.box_height  = h_ff;
   assign rsp.class_index = cls_ff;
   assign rsp.score       = sc_ff;
   assign rsp.cell_row    = row_out_ff;
   assign rsp.cell_col    = col_out_ff;
   assign rsp.box_slot    = slot_out_ff;
   assign rsp.last        = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_ff      <= '0;
         e_ff         <= '0;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         e_ff         <= e_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      score_ff    <= score_in;
      off_ff      <= off_in;
      num_ff      <= num_in;
      neg_ff      <= neg_in;
      edge_ff     <= edge_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      cls_ff      <= cls_in;
      sc_ff       <= sc_in;
      row_out_ff  <= row_out_in;
      col_out_ff  <= col_out_in;
      slot_out_ff <= slot_out_in;
      last_ff     <= last_in;
   end

endmodule

### tb/sv/yolo_grid_box_decoder_checker.sv
// Checker of the grid box decoder: watches both channels and the register port, predicts, compares.
`timescale 1ns / 1ps

module yolo_grid_box_decoder_checker import ygbd_pkg::*; #(
   parameter int GRID_SIZE      = 14,
   parameter int BOXES_PER_CELL = 2,
   parameter int CLASS_COUNT    = 20,
   parameter int VALUE_BITS     = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   ygbd_req_if                   req_chan,
   ygbd_rsp_if                   rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    detections_pending,
   output int                    detections_checked
);

   localparam int BOX_CHANNELS  = BOX_FIELDS * BOXES_PER_CELL;
   localparam int CELL_CHANNELS = BOX_CHANNELS + CLASS_COUNT;
   localparam longint ONE       = longint'(1) << FRAC_BITS;
   localparam longint EDGE_DIV  = longint'(2 * GRID_SIZE) * ONE;
   localparam longint SCORE_MAX = 65535;
   localparam int MAX_PRINTED   = 100;

   typedef struct packed {
      logic signed [PIX_W-1:0] box_x;
      logic signed [PIX_W-1:0] box_y;
      logic signed [PIX_W-1:0] box_width;
      logic signed [PIX_W-1:0] box_height;
      logic [CLASS_OUT_W-1:0]  class_index;
      logic [SCORE_W-1:0]      score;
      logic [POS_OUT_W-1:0]    cell_row;
      logic [POS_OUT_W-1:0]    cell_col;
      logic                    box_slot;
      logic                    last;
   } detection_type;

   cfg_type                         cfg;
   logic signed [VALUE_BITS-1:0]    box_store [BOX_CHANNELS];
   logic signed [VALUE_BITS-1:0]    best_score;
   logic [CLASS_OUT_W-1:0]          best_class;
   logic [$clog2(CELL_CHANNELS)-1:0] chan_idx;
   logic [cell_w(GRID_SIZE)-1:0]    col_idx;
   logic [cell_w(GRID_SIZE)-1:0]    row_idx;
   detection_type                   detections_due [$];
   detection_type                   want;
   string                           origin;
   int                              errors = 0;
   int                              checked = 0;

   task automatic report_error(input string msg);
      if (errors < MAX_PRINTED) $display("%0t ERROR: %s", $realtime, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic signed [31:0] got,
                              input logic signed [31:0] exp_val);
      if (got !== exp_val)
         report_error($sformatf("%s: %s is %0d, expected %0d", origin, name, got, exp_val));
   endtask

   function automatic logic signed [PIX_W-1:0] clamp_pixel(input longint v);
      if (v < longint'(PIX_MIN)) return PIX_MIN;
      if (v > longint'(PIX_MAX)) return PIX_MAX;
      return PIX_W'(v);
   endfunction

   // One edge of a box: the center in grid units plus or minus half the size, scaled to pixels.
   function automatic logic signed [PIX_W-1:0] pixel_edge(input longint offset,
         input longint grid_pos, input longint size, input longint dir, input longint dim);
      longint num;
      num = (2 * (offset + grid_pos * ONE) + dir * GRID_SIZE * size) * dim;
      return clamp_pixel(num / EDGE_DIV);
   endfunction

   task automatic decode_value(input logic signed [VALUE_BITS-1:0] v, input logic fs);
      detection_type hit;
      longint        thr;
      longint        conf;
      longint        prod;
      longint        sc;
      int            found;
      found = 0;
      if (fs) begin
         chan_idx = '0;
         col_idx  = '0;
         row_idx  = '0;
      end
      if (chan_idx < BOX_CHANNELS) begin
         box_store[chan_idx] = v;
      end else if (chan_idx == BOX_CHANNELS || v > best_score) begin
         best_score = v;
         best_class = CLASS_OUT_W'(chan_idx - BOX_CHANNELS);
      end
      if (chan_idx == CELL_CHANNELS - 1) begin
         thr = longint'(cfg.score_threshold);
         for (int k = 0; k < BOXES_PER_CELL; k++) begin
            conf = longint'(box_store[BOX_FIELDS * k + FLD_CONF]);
            prod = conf * longint'(best_score);
            if (conf > thr && prod > (thr << FRAC_BITS)) begin
               hit.box_x = pixel_edge(box_store[BOX_FIELDS * k + FLD_X], col_idx,
                                      box_store[BOX_FIELDS * k + FLD_W], -1, cfg.image_width);
               hit.box_width = pixel_edge(box_store[BOX_FIELDS * k + FLD_X], col_idx,
                                          box_store[BOX_FIELDS * k + FLD_W], 1, cfg.image_width);
               hit.box_y = pixel_edge(box_store[BOX_FIELDS * k + FLD_Y], row_idx,
                                      box_store[BOX_FIELDS * k + FLD_H], -1, cfg.image_height);
               hit.box_height = pixel_edge(box_store[BOX_FIELDS * k + FLD_Y], row_idx,
                                           box_store[BOX_FIELDS * k + FLD_H], 1, cfg.image_height);
               // The width fields so far hold the right and bottom edges.
               hit.box_width  = clamp_pixel(longint'(hit.box_width) - longint'(hit.box_x));
               hit.box_height = clamp_pixel(longint'(hit.box_height) - longint'(hit.box_y));
               sc = prod >>> FRAC_BITS;
               if (sc > SCORE_MAX) sc = SCORE_MAX;
               hit.score       = SCORE_W'(sc);
               hit.class_index = best_class;
               hit.cell_row    = POS_OUT_W'(row_idx);
               hit.cell_col    = POS_OUT_W'(col_idx);
               hit.box_slot    = 1'(k);
               hit.last        = 1'b0;
               detections_due.insert(detections_due.size(), hit);
               found++;
            end
         end
         if (found > 0) detections_due[detections_due.size() - 1].last = 1'b1;
         chan_idx = '0;
         if (col_idx == GRID_SIZE - 1) begin
            col_idx = '0;
            row_idx = (row_idx == GRID_SIZE - 1) ? '0 : row_idx + 1'b1;
         end else begin
            col_idx = col_idx + 1'b1;
         end
      end else begin
         chan_idx = chan_idx + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.score_threshold = THR_RESET;
         cfg.image_width     = DIM_RESET;
         cfg.image_height    = DIM_RESET;
         best_score = '0;
         best_class = '0;
         chan_idx   = '0;
         col_idx    = '0;
         row_idx    = '0;
         detections_due.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (detections_due.size() == 0) begin
               report_error("detection transfer with no detection expected");
            end else begin
               want = detections_due.pop_front();
               origin = $sformatf("cell %0d,%0d slot %0d", want.cell_row, want.cell_col,
                                  want.box_slot);
               check_field("box_x", rsp_chan.box_x, want.box_x);
               check_field("box_y", rsp_chan.box_y, want.box_y);
               check_field("box_width", rsp_chan.box_width, want.box_width);
               check_field("box_height", rsp_chan.box_height, want.box_height);
               check_field("class_index", rsp_chan.class_index, want.class_index);
               check_field("score", rsp_chan.score, want.score);
               check_field("cell_row", rsp_chan.cell_row, want.cell_row);
               check_field("cell_col", rsp_chan.cell_col, want.cell_col);
               check_field("box_slot", rsp_chan.box_slot, want.box_slot);
               check_field("last", rsp_chan.last, want.last);
               checked++;
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_SCORE_THRESHOLD: cfg.score_threshold = csr_pwdata[THR_W-1:0];
               REG_IMAGE_WIDTH:     cfg.image_width     = csr_pwdata[DIM_W-1:0];
               REG_IMAGE_HEIGHT:    cfg.image_height    = csr_pwdata[DIM_W-1:0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) decode_value(req_chan.value, req_chan.frame_start);
      end
      fail_count         <= errors;
      detections_pending <= detections_due.size();
      detections_checked <= checked;
   end

endmodule

### tb/sv/yolo_grid_box_decoder_test.sv
// Top of the grid box decoder testbench: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps

module yolo_grid_box_decoder_test import ygbd_pkg::*;;

   localparam int GRID_SIZE      = 14;
   localparam int BOXES_PER_CELL = 2;
   localparam int CLASS_COUNT    = 20;
   localparam int VALUE_BITS     = 16;

   localparam int BOX_CHANNELS  = BOX_FIELDS * BOXES_PER_CELL;
   localparam int CELL_CHANNELS = BOX_CHANNELS + CLASS_COUNT;
   localparam int SETTLE_CYCLES = 120;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int detections_pending;
   int detections_checked;
   int cycle_count = 0;
   int values_sent = 0;
   int settings_used = 1;
   int cur_thr = int'(THR_RESET);
   int lane = 0;
   bit quiet = 1'b0;
   bit idle_req = 1'b1;
   bit stall_mode = 1'b1;
   logic signed [VALUE_BITS-1:0] prev_class = '0;

   ygbd_req_if #(.VALUE_BITS(VALUE_BITS)) req_chan ();
   ygbd_rsp_if rsp_chan ();

   yolo_grid_box_decoder #(
      .GRID_SIZE(GRID_SIZE),
      .BOXES_PER_CELL(BOXES_PER_CELL),
      .CLASS_COUNT(CLASS_COUNT),
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   yolo_grid_box_decoder_checker #(
      .GRID_SIZE(GRID_SIZE),
      .BOXES_PER_CELL(BOXES_PER_CELL),
      .CLASS_COUNT(CLASS_COUNT),
      .VALUE_BITS(VALUE_BITS)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_pready(csr_pready),
      .fail_count(fail_count),
      .detections_pending(detections_pending),
      .detections_checked(detections_checked)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d detections outstanding", cycle_count,
                  detections_pending);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result side: random stall bursts, switched on and off in stretches.
   always begin
      @(negedge clock);
      if (!quiet && stall_mode && $urandom_range(0, 5) == 0) begin
         rsp_chan.ready = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      rsp_chan.ready = 1'b1;
      if ($urandom_range(0, 99) == 0) stall_mode = !stall_mode;
   end

   // Called at a falling edge; returns at the falling edge after the transfer, valid still high.
   task automatic send_value(input logic signed [VALUE_BITS-1:0] v, input logic fs);
      if (!quiet && idle_req && $urandom_range(0, 7) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_chan.valid       = 1'b1;
      req_chan.value       = v;
      req_chan.frame_start = fs;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      values_sent++;
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [CSR_DATA_W-1:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Half the time the bits above the field carry junk that the block must mask off.
   function automatic logic [CSR_DATA_W-1:0] with_junk(input int v, input int width);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom_range(0, 1) ? CSR_DATA_W'($urandom) : '0;
      return (junk << width) | CSR_DATA_W'(v);
   endfunction

   task automatic set_config(input int thr, input int w, input int h);
      write_reg(REG_SCORE_THRESHOLD, with_junk(thr, THR_W));
      write_reg(REG_IMAGE_WIDTH, with_junk(w, DIM_W));
      write_reg(REG_IMAGE_HEIGHT, with_junk(h, DIM_W));
      cur_thr = thr;
      settings_used++;
   endtask

   // Registers change only once every detection is out and the last cell has finished.
   task automatic wait_idle();
      req_chan.valid = 1'b0;
      while (detections_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic signed [VALUE_BITS-1:0] pick_value(input int ch);
      logic signed [VALUE_BITS-1:0] v;
      int roll;
      roll = $urandom_range(0, 7);
      if (ch < BOX_CHANNELS && ch % BOX_FIELDS != FLD_CONF) begin
         v = (roll < 2) ? VALUE_BITS'($urandom) : VALUE_BITS'($urandom_range(0, 16384));
      end else if (ch < BOX_CHANNELS) begin
         // Confidence clusters around the threshold so the strict compare is exercised.
         if (roll < 2) v = VALUE_BITS'($urandom);
         else if (roll < 4) v = VALUE_BITS'(cur_thr + int'($urandom_range(0, 6)) - 3);
         else v = VALUE_BITS'($urandom_range(0, 32767));
      end else begin
         if (roll == 0 && ch > BOX_CHANNELS) v = prev_class;
         else if (roll < 3) v = VALUE_BITS'($urandom);
         else v = VALUE_BITS'($urandom_range(0, 32767));
         prev_class = v;
      end
      return v;
   endfunction

   // Starts a grid, then either runs on without interruption or restarts at random points.
   task automatic run_random(input int count, input bit whole_grid);
      logic fs;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 63) == 0) idle_req = !idle_req;
         fs = (n == 0) || (!whole_grid && $urandom_range(0, 149) == 0);
         if (fs) lane = 0;
         send_value(pick_value(lane), fs);
         lane = (lane == CELL_CHANNELS - 1) ? 0 : lane + 1;
      end
   endtask

   // A grid restarted after three values, then one cell with extreme box fields, a
   // product exactly at the threshold for the second box and tied best class scores.
   task automatic run_directed();
      logic signed [VALUE_BITS-1:0] cls;
      send_value(16'sh7FFF, 1'b1);
      send_value(16'sh8000, 1'b0);
      send_value(16'sh0000, 1'b0);
      send_value(16'sh7FFF, 1'b1);
      send_value(16'sh8000, 1'b0);
      send_value(16'sh7FFF, 1'b0);
      send_value(16'sh7FFF, 1'b0);
      send_value(16'sh7FFF, 1'b0);
      send_value(16'sh8000, 1'b0);
      send_value(16'sh7FFF, 1'b0);
      send_value(16'sh4000, 1'b0);
      send_value(16'sh0001, 1'b0);
      send_value(16'sh4000, 1'b0);
      for (int c = 0; c < CLASS_COUNT; c++) begin
         if (c == 0) cls = 16'sh8000;
         else if (c == 2 || c == 3 || c == CLASS_COUNT - 1) cls = VALUE_BITS'(THR_RESET);
         else if (c % 2 == 1) cls = 16'sd1200;
         else cls = 16'shFFFF;
         send_value(cls, 1'b0);
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.value       = '0;
      req_chan.frame_start = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      run_random(200, 1'b0);

      wait_idle();
      set_config(0, 4096, 4096);
      run_random(250, 1'b0);

      wait_idle();
      set_config(16384, 1, 1);
      run_random(250, 1'b0);

      // Fifteen cells without a restart, so the column wraps into the next row.
      wait_idle();
      set_config($urandom_range(1, 16383), $urandom_range(1, 4096), $urandom_range(1, 4096));
      run_random((GRID_SIZE + 1) * CELL_CHANNELS, 1'b1);

      wait_idle();
      set_config(int'(THR_RESET), int'(DIM_RESET), int'(DIM_RESET));
      write_reg(REG_UNUSED, $urandom);
      run_random(250, 1'b0);

      wait_idle();
      set_config($urandom_range(0, 16384), $urandom_range(1, 4096), $urandom_range(1, 4096));
      quiet = 1'b1;
      run_random(150, 1'b0);

      wait_idle();
      $display("Sent %0d prediction values under %0d register settings, one row wrap included;",
               values_sent, settings_used);
      $display("compared %0d detections field by field.", detections_checked);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
